FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the key/value table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ukvt_pkg.sv
// Shared types and codes of the unique key/value table.
package ukvt_pkg;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_LOOKUP = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_MISSDUP = 2'd1,
		STAT_FULL    = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_EXEC
	} state_t;

	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;
	// Memory word: valid bit, key, value.
	localparam int WORD_W  = 1 + KEY_W + VALUE_W;

	typedef struct packed {
		logic clear;   // write a zero word at the scan index
		logic start;   // capture the item and restart the scan
		logic read;    // read the entry at the scan index
		logic commit;  // apply the operation and load the result
	} cmd_t;

	typedef struct packed {
		logic last;      // scan index is at the final entry
		logic out_free;  // result register can take a new result
	} sts_t;

endpackage

FILE: hw/rtl/unique_key_value_table.sv
// Unique key/value table: up to TABLE_DEPTH entries of a 32-bit key and a 32-bit value,
// kept in one single-port-read entry memory. For each request (insert, remove, lookup)
// the key is compared against one entry per cycle through the memory read port, then a
// drain state compares the last read and an execute state writes the entry and loads
// the result register. in_stall is high from the scan until the request is committed,
// so a new request is taken only once the last one is through. After reset a clearing
// pass zeroes every memory entry, with in_stall high. A finished result waits in its
// own register, so the next request is taken while the result is still held; that
// request then waits in its execute state until the held result is transferred.
module unique_key_value_table #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     kind,
	input  logic signed [ukvt_pkg::KEY_W-1:0] key,
	input  logic [ukvt_pkg::VALUE_W-1:0]   value_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [ukvt_pkg::VALUE_W-1:0]   value_out,
	output logic [ukvt_pkg::COUNT_W-1:0]   count
);
	import ukvt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ukvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ukvt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.kind      (kind),
		.key       (key),
		.value_in  (value_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.value_out (value_out),
		.count     (count)
	);

endmodule

FILE: hw/rtl/ukvt_ctrl.sv
// Controller state machine of the unique key/value table.
`include "assert_macros.svh"

module ukvt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ukvt_pkg::sts_t sts,
	output ukvt_pkg::cmd_t cmd
);
	import ukvt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.clear  = (state_q == S_CLEAR);
		cmd.start  = (state_q == S_IDLE) && in_valid;
		cmd.read   = (state_q == S_SCAN);
		cmd.commit = (state_q == S_EXEC) && sts.out_free;
		in_stall   = (state_q != S_IDLE);
	end

	`ASSERT_NEXT(a_start_scans, clk, arst_n, cmd.start, state_q == S_SCAN, "transfer did not start a scan")
	`ASSERT_NEXT(a_scan_drains, clk, arst_n, cmd.read && sts.last, state_q == S_DRAIN, "scan did not end in drain")
	`ASSERT_ALWAYS(a_commit_free, clk, arst_n, !cmd.commit || sts.out_free, "commit while result held")

endmodule

FILE: hw/rtl/ukvt_dp.sv
// Datapath of the unique key/value table: entry memory, scan, result register.
`include "assert_macros.svh"

module ukvt_dp #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ukvt_pkg::cmd_t                 cmd,
	output ukvt_pkg::sts_t                 sts,
	input  logic [1:0]                     kind,
	input  logic signed [ukvt_pkg::KEY_W-1:0] key,
	input  logic [ukvt_pkg::VALUE_W-1:0]   value_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [ukvt_pkg::VALUE_W-1:0]   value_out,
	output logic [ukvt_pkg::COUNT_W-1:0]   count
);
	import ukvt_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [WORD_W-1:0] mem [TABLE_DEPTH];

	logic [IW-1:0]      idx_q;
	logic [1:0]         kind_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] val_q;
	logic [CW-1:0]      cnt_q;

	logic               rvalid_s1;
	logic [IW-1:0]      idx_s1;
	logic [WORD_W-1:0]  rdata_s1;

	logic               hit_q;
	logic [IW-1:0]      hit_idx_q;
	logic [VALUE_W-1:0] hit_val_q;
	logic               free_q;
	logic [IW-1:0]      free_idx_q;

	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [VALUE_W-1:0] value_out_q;
	logic [COUNT_W-1:0] count_q;

	logic               wr_en;
	logic [IW-1:0]      wr_addr;
	logic [WORD_W-1:0]  wr_data;
	logic [1:0]         status_c;
	logic [VALUE_W-1:0] vout_c;
	logic [CW-1:0]      cnt_c;
	logic               cwr_en;
	logic [IW-1:0]      cwr_addr;
	logic [WORD_W-1:0]  cwr_data;

	assign sts.last     = (idx_q == IW'(TABLE_DEPTH - 1));
	assign sts.out_free = !out_valid_q || !out_stall;

	// Operation outcome from the scan flags.
	always_comb begin
		status_c = STAT_OK;
		vout_c   = '0;
		cnt_c    = cnt_q;
		cwr_en   = 1'b0;
		cwr_addr = free_idx_q;
		cwr_data = {1'b1, key_q, val_q};
		unique case (kind_q)
			KIND_INSERT: begin
				if (hit_q) begin
					status_c = STAT_MISSDUP;
				end else if (!free_q) begin
					status_c = STAT_FULL;
				end else begin
					cwr_en = 1'b1;
					cnt_c  = cnt_q + 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (!hit_q) begin
					status_c = STAT_MISSDUP;
				end else begin
					cwr_en   = 1'b1;
					cwr_addr = hit_idx_q;
					cwr_data = '0;
					if (cnt_q != '0) cnt_c = cnt_q - 1'b1;
				end
			end
			KIND_LOOKUP: begin
				if (!hit_q) begin
					status_c = STAT_MISSDUP;
				end else begin
					vout_c = hit_val_q;
				end
			end
			default: begin
				status_c = STAT_OK;
			end
		endcase
	end

	always_comb begin
		wr_en   = cmd.clear || (cmd.commit && cwr_en);
		wr_addr = cmd.clear ? idx_q : cwr_addr;
		wr_data = cmd.clear ? '0 : cwr_data;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rdata_s1 <= mem[idx_q];
			idx_s1   <= idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q <= kind;
			key_q  <= key;
			val_q  <= value_in;
		end
		if (cmd.commit) begin
			status_q    <= status_c;
			value_out_q <= vout_c;
			count_q     <= COUNT_W'(cnt_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cnt_q       <= '0;
			rvalid_s1   <= 1'b0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			hit_val_q   <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= cmd.read;
			if (cmd.start) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (cmd.clear || cmd.read) begin
				idx_q <= idx_q + 1'b1;
			end
			// Compare the entry read in the previous cycle.
			if (rvalid_s1) begin
				if (rdata_s1[WORD_W-1] && !hit_q &&
				    rdata_s1[WORD_W-2 -: KEY_W] == key_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= idx_s1;
					hit_val_q <= rdata_s1[VALUE_W-1:0];
				end
				if (!rdata_s1[WORD_W-1] && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_s1;
				end
			end
			if (cmd.commit) begin
				cnt_q       <= cnt_c;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value_out = value_out_q;
	assign count     = count_q;

	`ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= CW'(TABLE_DEPTH), "entry count above depth")
	`ASSERT_NEXT(a_commit_out, clk, arst_n, cmd.commit, out_valid_q, "commit did not load a result")
	`ASSERT_NEXT(a_full_status, clk, arst_n, cmd.commit && kind_q == KIND_INSERT && !hit_q && !free_q, status_q == STAT_FULL && cnt_q == CW'(TABLE_DEPTH), "full insert misreported")

endmodule

FILE: tb/unique_key_value_table_checker.sv
// Checker for the unique key/value table: predicts each reply and compares it with the block.
module unique_key_value_table_checker #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [1:0]                       kind,
	input  logic [ukvt_pkg::KEY_W-1:0]       key,
	input  logic [ukvt_pkg::VALUE_W-1:0]     value_in,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [1:0]                       status,
	input  logic [ukvt_pkg::VALUE_W-1:0]     value_out,
	input  logic [ukvt_pkg::COUNT_W-1:0]     count,
	output int                               fail_count,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import ukvt_pkg::*;

	typedef struct packed {
		logic [1:0]         status;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
	} reply_t;

	logic               shadow_valid [TABLE_DEPTH];
	logic [KEY_W-1:0]   shadow_key   [TABLE_DEPTH];
	logic [VALUE_W-1:0] shadow_value [TABLE_DEPTH];
	int                 shadow_count;
	reply_t             expected_replies [$];
	reply_t             want;

	// Apply one request to the shadow table and return the reply it should give.
	function automatic reply_t apply_request(input logic [1:0] op, input logic [KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v);
		int     hit;
		int     slot;
		reply_t r;
		hit  = -1;
		slot = -1;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (hit < 0 && shadow_valid[i] && shadow_key[i] == k)
				hit = i;
			if (slot < 0 && !shadow_valid[i])
				slot = i;
		end
		r.status = STAT_OK;
		r.value  = '0;
		case (op)
			KIND_INSERT: begin
				if (hit >= 0) begin
					r.status = STAT_MISSDUP;
				end else if (slot < 0) begin
					r.status = STAT_FULL;
				end else begin
					shadow_valid[slot] = 1'b1;
					shadow_key[slot]   = k;
					shadow_value[slot] = v;
					shadow_count++;
				end
			end
			KIND_REMOVE: begin
				if (hit < 0) begin
					r.status = STAT_MISSDUP;
				end else begin
					shadow_valid[hit] = 1'b0;
					if (shadow_count > 0)
						shadow_count--;
				end
			end
			KIND_LOOKUP: begin
				if (hit < 0)
					r.status = STAT_MISSDUP;
				else
					r.value = shadow_value[hit];
			end
			default: begin
				// unused kind: no change, plain ok with the current count
			end
		endcase
		r.count = shadow_count[COUNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				shadow_valid[i] = 1'b0;
			shadow_count = 0;
			expected_replies.delete();
			pending = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_replies.push_back(apply_request(kind, key, value_in));
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					$error("result with no request waiting: status %0d value_out %h count %0d",
						status, value_out, count);
					fail_count++;
				end else begin
					want = expected_replies.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fail_count++;
					end
					if (value_out !== want.value) begin
						$error("value_out: expected %h, actual %h", want.value, value_out);
						fail_count++;
					end
					if (count !== want.count) begin
						$error("count: expected %0d, actual %0d", want.count, count);
						fail_count++;
					end
				end
			end
			pending = expected_replies.size();
		end
	end

endmodule

FILE: tb/unique_key_value_table_test.sv
// Testbench top for the unique key/value table: stimulus, reply pacing and verdict.
module unique_key_value_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ukvt_pkg::*;

	localparam int         DEPTH        = 16;
	localparam logic [1:0] KIND_UNUSED  = 2'd3;
	localparam int         RANDOM_ITEMS = 1370;
	localparam int         POOL_CAP     = 40;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         LONG_HOLD    = 300;
	localparam int         HOLD_AT      = 150;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            kind;
	logic signed [KEY_W-1:0] key;
	logic [VALUE_W-1:0]    value_in;
	logic                  out_valid;
	logic                  out_stall;
	logic [1:0]            status;
	logic [VALUE_W-1:0]    value_out;
	logic [COUNT_W-1:0]    count;
	int                    fail_count;
	int                    pending;
	logic                  send_burst;
	logic [KEY_W-1:0]      key_pool [$];

	unique_key_value_table #(.TABLE_DEPTH(DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .key(key), .value_in(value_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .value_out(value_out), .count(count)
	);

	unique_key_value_table_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .key(key), .value_in(value_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .value_out(value_out), .count(count),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offer one request, entered and left at a falling edge; valid stays high between requests only when no gap is drawn.
	task automatic offer(input logic [1:0] op, input logic [KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= op;
		key      <= k;
		value_in <= v;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Reply side: random stalls, stretches without stalls, one long hold to back the block up.
	initial begin
		int  wait_cycles;
		int  taken;
		bit  burst;
		bit  held;
		taken = 0;
		burst = 1'b0;
		held  = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held && taken >= HOLD_AT) begin
				wait_cycles = LONG_HOLD;
				held = 1'b1;
			end else begin
				wait_cycles = burst ? 0 : $urandom_range(0, 6);
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
			taken++;
			if ($urandom_range(0, 19) == 0)
				burst = !burst;
			@(negedge clk);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int               sent;
		int               phase_len;
		int               insert_pct;
		int               pick;
		logic [1:0]       op;
		logic [KEY_W-1:0] k;
		logic [VALUE_W-1:0] v;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		kind       = '0;
		key        = '0;
		value_in   = '0;
		send_burst = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// misses on an empty table, key extremes, a duplicate, a stored zero, the unused kind
		offer(KIND_LOOKUP, 32'h0000_0000, 32'h0);
		offer(KIND_REMOVE, 32'h8000_0000, 32'h0);
		offer(KIND_INSERT, 32'h8000_0000, 32'h0000_0000);
		offer(KIND_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
		offer(KIND_INSERT, 32'h8000_0000, 32'h1234_5678);
		offer(KIND_LOOKUP, 32'h8000_0000, 32'hffff_ffff);
		offer(KIND_LOOKUP, 32'h7fff_ffff, 32'h0);
		offer(KIND_UNUSED, 32'h7fff_ffff, 32'hffff_ffff);
		offer(KIND_INSERT, 32'hffff_ffff, 32'h5555_aaaa);
		offer(KIND_INSERT, 32'h0000_0000, 32'haaaa_5555);
		offer(KIND_REMOVE, 32'h7fff_ffff, 32'h0);
		offer(KIND_LOOKUP, 32'h7fff_ffff, 32'h0);
		offer(KIND_INSERT, 32'h0000_0001, 32'h0000_0001);
		key_pool.push_back(32'h8000_0000);
		key_pool.push_back(32'h7fff_ffff);
		key_pool.push_back(32'hffff_ffff);
		key_pool.push_back(32'h0000_0000);
		key_pool.push_back(32'h0000_0001);
		// fill the table, then push past full and repeat a key while full
		for (int i = 0; i < DEPTH - 4; i++) begin
			k = $urandom;
			key_pool.push_back(k);
			offer(KIND_INSERT, k, $urandom);
		end
		k = $urandom;
		key_pool.push_back(k);
		offer(KIND_INSERT, k, $urandom);
		offer(KIND_INSERT, 32'hffff_ffff, 32'h0);
		while (key_pool.size() < 28)
			key_pool.push_back($urandom);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0:       insert_pct = 75;
				1:       insert_pct = 45;
				default: insert_pct = 15;
			endcase
			send_burst = ($urandom_range(0, 3) == 0);
			phase_len  = $urandom_range(40, 120);
			for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
				case ($urandom_range(0, 9))
					0:       v = '0;
					1:       v = '1;
					default: v = $urandom;
				endcase
				if ($urandom_range(0, 99) < 12) begin
					// noise: any kind with a fresh key (a pooled key for inserts once the pool is full)
					op = 2'($urandom_range(0, 3));
					k  = $urandom;
					if (op == KIND_INSERT) begin
						if (key_pool.size() < POOL_CAP)
							key_pool.push_back(k);
						else
							k = key_pool[$urandom_range(0, key_pool.size() - 1)];
					end
				end else begin
					k    = key_pool[$urandom_range(0, key_pool.size() - 1)];
					pick = $urandom_range(0, 99);
					if (pick < insert_pct)
						op = KIND_INSERT;
					else if (pick < insert_pct + (100 - insert_pct) / 2)
						op = KIND_REMOVE;
					else
						op = KIND_LOOKUP;
				end
				offer(op, k, v);
				sent++;
			end
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DEPTH + 3 + 20) @(negedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ukvt_pkg.sv
hw/rtl/ukvt_ctrl.sv
hw/rtl/ukvt_dp.sv
hw/rtl/unique_key_value_table.sv
tb/unique_key_value_table_checker.sv
tb/unique_key_value_table_test.sv
